### rtl/core/rocdf_pkg.sv
package rocdf_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int TIME_BITS_DEFAULT  = 32;
   localparam int RATE_BITS          = 32;
   localparam int MODE_BITS          = 2;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 32;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CLASS_BITS         = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_RATE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_RATE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE     = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_LEFT   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RIGHT  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BOTH   = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_EITHER = 2'd3;

   // How the front end classified a sample before handing it to the back end.
   typedef enum logic [CLASS_BITS-1:0] {
      CLS_FIRST  = 2'd0,
      CLS_SECOND = 2'd1,
      CLS_NORMAL = 2'd2,
      CLS_FLUSH  = 2'd3
   } item_class_type;

   typedef struct packed {
      logic signed [RATE_BITS-1:0] max_rate;
      logic signed [RATE_BITS-1:0] min_rate;
      logic [MODE_BITS-1:0]        mode;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Combine the left and right limit checks according to the filter mode.
   function automatic logic combine_checks(input logic [MODE_BITS-1:0] mode,
                                           input logic left_bad,
                                           input logic right_bad,
                                           input logic has_next);
      logic result;
      case (mode)
         MODE_LEFT:   result = left_bad;
         MODE_RIGHT:  result = has_next & right_bad;
         MODE_BOTH:   result = has_next ? (left_bad & right_bad) : left_bad;
         MODE_EITHER: result = has_next ? (left_bad | right_bad) : left_bad;
         default:     result = left_bad;
      endcase
      return result;
   endfunction

endpackage

### rtl/core/rocdf_if.sv
interface rocdf_req_if
   import rocdf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] sample_value;
   logic [TIME_BITS-1:0]         sample_time;
   logic                         present;
   logic                         end_of_series;

   modport source (output valid, output sample_value, output sample_time,
                   output present, output end_of_series, input ready);
   modport sink   (input valid, input sample_value, input sample_time,
                   input present, input end_of_series, output ready);
endinterface

interface rocdf_rsp_if
   import rocdf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] out_value;
   logic [TIME_BITS-1:0]         out_time;
   logic                         rejected;

   modport source (output valid, output out_value, output out_time,
                   output rejected, input ready);
   modport sink   (input valid, input out_value, input out_time,
                   input rejected, output ready);
endinterface

### rtl/core/rocdf_rate_check.sv
module rocdf_rate_check
   import rocdf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
   input  logic signed [VALUE_BITS:0] delta_value,
   input  logic signed [TIME_BITS:0]  delta_time,
   input  logic signed [RATE_BITS-1:0] max_rate,
   input  logic signed [RATE_BITS-1:0] min_rate,
   output logic                        violation
);
   localparam int PROD_BITS = RATE_BITS + TIME_BITS + 1;
   localparam int CMP_BITS  = ((VALUE_BITS + 1 > PROD_BITS) ? VALUE_BITS + 1 : PROD_BITS) + 1;

   logic signed [PROD_BITS-1:0] prod_max;
   logic signed [PROD_BITS-1:0] prod_min;
   logic signed [CMP_BITS-1:0]  diff_max;
   logic signed [CMP_BITS-1:0]  diff_min;
   logic gt_max, lt_max, gt_min, lt_min;
   logic dt_zero, dt_neg, dv_zero;
   logic above, below;

   // The rate limit times the time step is compared with the value step,
   // exactly, so no quotient is ever formed.
   assign prod_max = PROD_BITS'(max_rate) * PROD_BITS'(delta_time);
   assign prod_min = PROD_BITS'(min_rate) * PROD_BITS'(delta_time);
   assign diff_max = CMP_BITS'(delta_value) - CMP_BITS'(prod_max);
   assign diff_min = CMP_BITS'(delta_value) - CMP_BITS'(prod_min);

   assign lt_max = diff_max[CMP_BITS-1];
   assign gt_max = !diff_max[CMP_BITS-1] && (diff_max != '0);
   assign lt_min = diff_min[CMP_BITS-1];
   assign gt_min = !diff_min[CMP_BITS-1] && (diff_min != '0);

   assign dt_zero = (delta_time == '0);
   assign dt_neg  = delta_time[TIME_BITS];
   assign dv_zero = (delta_value == '0);

   // With a zero time step the products vanish and the sign of the value
   // step decides; a flat step counts as rate zero against both limits.
   assign above = dt_neg ? lt_max
                         : (gt_max || (dt_zero && dv_zero && max_rate[RATE_BITS-1]));
   assign below = dt_neg ? gt_min
                         : (lt_min || (dt_zero && dv_zero && !min_rate[RATE_BITS-1]
                                       && (min_rate != '0)));
   assign violation = above || below;
endmodule

### rtl/core/rocdf_queue.sv
module rocdf_queue
   import rocdf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [IDX_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == COUNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### rtl/core/rocdf_front.sv
module rocdf_front
   import rocdf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT,
   localparam int ENTRY_BITS = CLASS_BITS + 2 * VALUE_BITS + 2 * TIME_BITS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   rocdf_req_if.sink             req_chan,
   input  queue_status_type      queue_status,
   output logic                  push,
   output logic [ENTRY_BITS-1:0] push_data
);
   typedef struct packed {
      item_class_type               cls;
      logic signed [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]         stamp;
      logic signed [VALUE_BITS:0]   delta_value;
      logic signed [TIME_BITS:0]    delta_time;
   } entry_type;

   logic started_ff, started_in;
   logic pending_ff, pending_in;
   logic signed [VALUE_BITS-1:0] prev_value_ff;
   logic [TIME_BITS-1:0]         prev_time_ff;
   logic     accept;
   logic     take_sample;
   entry_type entry;

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take_sample    = accept && !req_chan.end_of_series && req_chan.present;

   // The step to the previous present sample does not depend on any
   // decision, so it is formed here; the back end forms only the steps to the kept sample.
   always_comb begin
      entry.value       = req_chan.sample_value;
      entry.stamp       = req_chan.sample_time;
      entry.delta_value = (VALUE_BITS + 1)'(req_chan.sample_value)
                          - (VALUE_BITS + 1)'(prev_value_ff);
      entry.delta_time  = $signed({1'b0, req_chan.sample_time})
                          - $signed({1'b0, prev_time_ff});
      started_in = started_ff;
      pending_in = pending_ff;
      push       = 1'b0;
      entry.cls  = CLS_NORMAL;
      if (accept) begin
         if (req_chan.end_of_series) begin
            entry.cls  = CLS_FLUSH;
            push       = pending_ff;
            started_in = 1'b0;
            pending_in = 1'b0;
         end else if (req_chan.present) begin
            push = 1'b1;
            if (pending_ff) begin
               entry.cls = CLS_NORMAL;
            end else if (started_ff) begin
               entry.cls  = CLS_SECOND;
               pending_in = 1'b1;
            end else begin
               entry.cls  = CLS_FIRST;
               started_in = 1'b1;
            end
         end
      end
   end

   assign push_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         prev_value_ff <= req_chan.sample_value;
         prev_time_ff  <= req_chan.sample_time;
      end
   end
endmodule

### rtl/core/rocdf_back.sv
module rocdf_back
   import rocdf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT,
   localparam int ENTRY_BITS = CLASS_BITS + 2 * VALUE_BITS + 2 * TIME_BITS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  queue_status_type      queue_status,
   input  logic [ENTRY_BITS-1:0] pop_data,
   output logic                  pop,
   rocdf_rsp_if.source           rsp_chan
);
   typedef struct packed {
      item_class_type               cls;
      logic signed [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]         stamp;
      logic signed [VALUE_BITS:0]   delta_value;
      logic signed [TIME_BITS:0]    delta_time;
   } entry_type;

   entry_type head;
   entry_type stage_ff;
   logic      stage_valid_ff, stage_valid_in;
   logic signed [VALUE_BITS:0] kept_dv_ff, kept_dv_in;
   logic signed [TIME_BITS:0]  kept_dt_ff, kept_dt_in;
   logic signed [VALUE_BITS:0] dv_to_kept, dv_to_pend;
   logic signed [TIME_BITS:0]  dt_to_kept, dt_to_pend;
   logic                       kept_moves;

   logic signed [VALUE_BITS-1:0] kept_value_ff;
   logic [TIME_BITS-1:0]         kept_time_ff;
   logic signed [VALUE_BITS-1:0] pend_value_ff;
   logic [TIME_BITS-1:0]         pend_time_ff;
   logic                         pend_left_ff;

   logic                         out_valid_ff, out_valid_in;
   logic signed [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic [TIME_BITS-1:0]         out_time_ff, out_time_in;
   logic                         out_rej_ff, out_rej_in;

   logic out_free, stage_load, fire;
   logic right_bad, kept_bad;
   logic rej_normal, rej_flush;

   assign head       = entry_type'(pop_data);
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign stage_load = !stage_valid_ff || out_free;
   assign fire       = stage_valid_ff && out_free;
   assign pop        = stage_load && !queue_status.empty;

   // The kept sample is read as the item leaves the queue. When the item
   // ahead keeps its held sample in the same cycle, that held sample becomes
   // the kept one, so the step to both is formed and the late decision picks.
   assign stage_valid_in = stage_load ? !queue_status.empty : stage_valid_ff;
   assign kept_moves = fire && (stage_ff.cls == CLS_NORMAL) && !rej_normal;
   assign dv_to_kept = (VALUE_BITS + 1)'(head.value) - (VALUE_BITS + 1)'(kept_value_ff);
   assign dt_to_kept = $signed({1'b0, head.stamp}) - $signed({1'b0, kept_time_ff});
   assign dv_to_pend = (VALUE_BITS + 1)'(head.value) - (VALUE_BITS + 1)'(pend_value_ff);
   assign dt_to_pend = $signed({1'b0, head.stamp}) - $signed({1'b0, pend_time_ff});
   assign kept_dv_in = kept_moves ? dv_to_pend : dv_to_kept;
   assign kept_dt_in = kept_moves ? dt_to_pend : dt_to_kept;

   rocdf_rate_check #(
      .VALUE_BITS (VALUE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_right_check (
      .delta_value (stage_ff.delta_value),
      .delta_time  (stage_ff.delta_time),
      .max_rate    (cfg.max_rate),
      .min_rate    (cfg.min_rate),
      .violation   (right_bad)
   );

   rocdf_rate_check #(
      .VALUE_BITS (VALUE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_kept_check (
      .delta_value (kept_dv_ff),
      .delta_time  (kept_dt_ff),
      .max_rate    (cfg.max_rate),
      .min_rate    (cfg.min_rate),
      .violation   (kept_bad)
   );

   assign rej_normal = combine_checks(cfg.mode, pend_left_ff, right_bad, 1'b1);
   assign rej_flush  = combine_checks(cfg.mode, pend_left_ff, 1'b0, 1'b0);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_time_in  = out_time_ff;
      out_rej_in   = out_rej_ff;
      if (fire) begin
         case (stage_ff.cls)
            CLS_FIRST: begin
               out_valid_in = 1'b1;
               out_value_in = stage_ff.value;
               out_time_in  = stage_ff.stamp;
               out_rej_in   = 1'b0;
            end
            CLS_NORMAL: begin
               out_valid_in = 1'b1;
               out_value_in = pend_value_ff;
               out_time_in  = pend_time_ff;
               out_rej_in   = rej_normal;
            end
            CLS_FLUSH: begin
               out_valid_in = 1'b1;
               out_value_in = pend_value_ff;
               out_time_in  = pend_time_ff;
               out_rej_in   = rej_flush;
            end
            default: begin
               out_valid_in = out_valid_ff && !rsp_chan.ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         stage_ff   <= head;
         kept_dv_ff <= kept_dv_in;
         kept_dt_ff <= kept_dt_in;
      end
      out_value_ff <= out_value_in;
      out_time_ff  <= out_time_in;
      out_rej_ff   <= out_rej_in;
      if (fire) begin
         case (stage_ff.cls)
            CLS_FIRST: begin
               kept_value_ff <= stage_ff.value;
               kept_time_ff  <= stage_ff.stamp;
            end
            CLS_SECOND: begin
               // The kept sample is the previous present one, so the step
               // formed by the front end is the left step.
               pend_value_ff <= stage_ff.value;
               pend_time_ff  <= stage_ff.stamp;
               pend_left_ff  <= right_bad;
            end
            CLS_NORMAL: begin
               if (!rej_normal) begin
                  kept_value_ff <= pend_value_ff;
                  kept_time_ff  <= pend_time_ff;
               end
               pend_value_ff <= stage_ff.value;
               pend_time_ff  <= stage_ff.stamp;
               pend_left_ff  <= rej_normal ? kept_bad : right_bad;
            end
            default: begin
               pend_left_ff <= pend_left_ff;
            end
         endcase
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_value = out_value_ff;
   assign rsp_chan.out_time  = out_time_ff;
   assign rsp_chan.rejected  = out_rej_ff;
endmodule

### rtl/core/rate_of_change_despike_filter.sv
// A first sample of a series returns through the queue, the stage register and
// the output register; any later sample is decided only after the transfer of
// the next present sample or of the end-of-series flush that follows it.
// Throughput: one item per cycle unless the receiver stalls, set by the combinational
// limit multiply and compare in the back end, which feeds the next kept-sample choice.
// Reset is synchronous and active high; it clears the registers, series state and queue.
module rate_of_change_despike_filter
   import rocdf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   rocdf_req_if.sink                 req_chan,
   rocdf_rsp_if.source               rsp_chan,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);
   localparam int ENTRY_BITS = CLASS_BITS + 2 * VALUE_BITS + 2 * TIME_BITS + 2;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type queue_status;
   logic             push, pop;
   logic [ENTRY_BITS-1:0] push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_RATE: cfg_in.max_rate = csr_data[RATE_BITS-1:0];
            CSR_MIN_RATE: cfg_in.min_rate = csr_data[RATE_BITS-1:0];
            CSR_MODE:     cfg_in.mode     = csr_data[MODE_BITS-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rocdf_front #(
      .VALUE_BITS (VALUE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   rocdf_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   rocdf_back #(
      .VALUE_BITS (VALUE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );
endmodule

### bench/despike_monitor.sv
`timescale 1ns / 1ps
module despike_monitor
   import rocdf_pkg::*;
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [VALUE_BITS_DEFAULT-1:0] req_sample_value,
   input  logic [TIME_BITS_DEFAULT-1:0]         req_sample_time,
   input  logic                                 req_present,
   input  logic                                 req_end_of_series,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [VALUE_BITS_DEFAULT-1:0] rsp_out_value,
   input  logic [TIME_BITS_DEFAULT-1:0]         rsp_out_time,
   input  logic                                 rsp_rejected,
   input  logic                                 csr_write,
   input  logic [CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [CSR_DATA_BITS-1:0]             csr_data,
   output int                                   failures,
   output int                                   outstanding
);
   localparam int REPORT_LINES = 40;

   typedef struct {
      logic signed [VALUE_BITS_DEFAULT-1:0] value;
      logic [TIME_BITS_DEFAULT-1:0]         stamp;
      logic                                 rejected;
   } decision_type;

   decision_type decisions_due[$];
   int fail_count = 0;
   int due_count = 0;

   logic signed [RATE_BITS-1:0]          rate_hi;
   logic signed [RATE_BITS-1:0]          rate_lo;
   logic [MODE_BITS-1:0]                 filter_mode;
   logic signed [VALUE_BITS_DEFAULT-1:0] kept_value;
   logic signed [VALUE_BITS_DEFAULT-1:0] held_value;
   logic [TIME_BITS_DEFAULT-1:0]         kept_stamp;
   logic [TIME_BITS_DEFAULT-1:0]         held_stamp;
   bit                                   kept_ok;
   bit                                   held_ok;

   assign failures    = fail_count;
   assign outstanding = due_count;

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LINES) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
      fail_count++;
   endtask

   // The limits are scaled by the time step instead of dividing. A negative
   // step turns the comparison round, as it would for a real quotient.
   function automatic bit rate_out_of_limits(input longint dv, input longint dt);
      longint hi_scaled;
      longint lo_scaled;
      bit     above;
      bit     below;
      if (dt == 0) begin
         above = (dv > 0) || (dv == 0 && rate_hi < 0);
         below = (dv < 0) || (dv == 0 && rate_lo > 0);
      end else begin
         hi_scaled = longint'(rate_hi) * dt;
         lo_scaled = longint'(rate_lo) * dt;
         above = (dt > 0) ? (dv > hi_scaled) : (dv < hi_scaled);
         below = (dt > 0) ? (dv < lo_scaled) : (dv > lo_scaled);
      end
      return above || below;
   endfunction

   function automatic bit held_is_spike(input bit has_next,
                                        input logic signed [VALUE_BITS_DEFAULT-1:0] next_value,
                                        input logic [TIME_BITS_DEFAULT-1:0] next_stamp);
      bit left_bad;
      bit right_bad;
      left_bad  = 1'b0;
      right_bad = 1'b0;
      if (kept_ok) begin
         left_bad = rate_out_of_limits(longint'(held_value) - longint'(kept_value),
                                       longint'(held_stamp) - longint'(kept_stamp));
      end
      if (has_next) begin
         right_bad = rate_out_of_limits(longint'(next_value) - longint'(held_value),
                                        longint'(next_stamp) - longint'(held_stamp));
      end
      case (filter_mode)
         MODE_LEFT:   return left_bad;
         MODE_RIGHT:  return has_next && right_bad;
         MODE_BOTH:   return has_next ? (left_bad && right_bad) : left_bad;
         default:     return has_next ? (left_bad || right_bad) : left_bad;
      endcase
   endfunction

   task automatic queue_decision(input logic signed [VALUE_BITS_DEFAULT-1:0] value,
                                 input logic [TIME_BITS_DEFAULT-1:0] stamp,
                                 input logic rejected);
      decision_type d;
      d.value    = value;
      d.stamp    = stamp;
      d.rejected = rejected;
      decisions_due.push_back(d);
   endtask

   task automatic clear_series();
      kept_value = '0;
      kept_stamp = '0;
      kept_ok    = 1'b0;
      held_value = '0;
      held_stamp = '0;
      held_ok    = 1'b0;
   endtask

   task automatic take_sample(input logic signed [VALUE_BITS_DEFAULT-1:0] value,
                              input logic [TIME_BITS_DEFAULT-1:0] stamp,
                              input logic present,
                              input logic flush);
      bit spike;
      if (flush) begin
         // A flushed sample has no right neighbor.
         if (held_ok) begin
            spike = held_is_spike(1'b0, '0, '0);
            queue_decision(held_value, held_stamp, spike);
         end
         clear_series();
      end else if (present) begin
         if (!kept_ok && !held_ok) begin
            kept_value = value;
            kept_stamp = stamp;
            kept_ok    = 1'b1;
            queue_decision(value, stamp, 1'b0);
         end else begin
            if (held_ok) begin
               spike = held_is_spike(1'b1, value, stamp);
               queue_decision(held_value, held_stamp, spike);
               if (!spike) begin
                  kept_value = held_value;
                  kept_stamp = held_stamp;
                  kept_ok    = 1'b1;
               end
            end
            held_value = value;
            held_stamp = stamp;
            held_ok    = 1'b1;
         end
      end
   endtask

   task automatic check_result();
      decision_type want;
      if (decisions_due.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: value %h time %h rejected %b",
                                   rsp_out_value, rsp_out_time, rsp_rejected));
      end else begin
         want = decisions_due.pop_front();
         if (rsp_out_value !== want.value) begin
            report_mismatch($sformatf("out_value expected %h, got %h",
                                      want.value, rsp_out_value));
         end
         if (rsp_out_time !== want.stamp) begin
            report_mismatch($sformatf("out_time expected %h, got %h",
                                      want.stamp, rsp_out_time));
         end
         if (rsp_rejected !== want.rejected) begin
            report_mismatch($sformatf("rejected expected %b, got %b for value %h time %h",
                                      want.rejected, rsp_rejected, want.value, want.stamp));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_series();
         rate_hi     = '0;
         rate_lo     = '0;
         filter_mode = MODE_LEFT;
         decisions_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAX_RATE: rate_hi = csr_data;
               CSR_MIN_RATE: rate_lo = csr_data;
               CSR_MODE:     filter_mode = csr_data[MODE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            take_sample(req_sample_value, req_sample_time, req_present, req_end_of_series);
         end
      end
      due_count = decisions_due.size();
   end

endmodule

### bench/tb_rate_of_change_despike_filter.sv
`timescale 1ns / 1ps
module tb_rate_of_change_despike_filter;
   import rocdf_pkg::*;

   localparam int PERIOD         = 12;
   localparam int RESET_CYCLES   = 12;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 200;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 1200000;

   // Index just past the register list; writes to it must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        failures;
   int                        outstanding;

   bit hold_request = 1'b0;
   bit tx_steady    = 1'b0;
   bit rx_free      = 1'b0;

   longint                 phase_hi;
   longint                 phase_lo;
   logic signed [31:0]     gen_value = '0;
   logic [31:0]            gen_stamp = '0;

   rocdf_req_if req_bus ();
   rocdf_rsp_if rsp_bus ();

   rate_of_change_despike_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   despike_monitor monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_sample_value  (req_bus.sample_value),
      .req_sample_time   (req_bus.sample_time),
      .req_present       (req_bus.present),
      .req_end_of_series (req_bus.end_of_series),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_out_value     (rsp_bus.out_value),
      .rsp_out_time      (rsp_bus.out_time),
      .rsp_rejected      (rsp_bus.rejected),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic signed [31:0] value, input logic [31:0] stamp,
                            input logic present, input logic flush);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample_value  <= value;
      req_bus.sample_time   <= stamp;
      req_bus.present       <= present;
      req_bus.end_of_series <= flush;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_flush();
      send_item($urandom, $urandom, 1'($urandom_range(0, 1)), 1'b1);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic signed [31:0] hi, input logic signed [31:0] lo,
                                 input logic [MODE_BITS-1:0] md, input bit spare);
      write_reg(CSR_MAX_RATE, hi);
      write_reg(CSR_MIN_RATE, lo);
      write_reg(CSR_MODE, {{(CSR_DATA_BITS-MODE_BITS){1'b0}}, md});
      if (spare) write_reg(CSR_SPARE, $urandom);
      csr_write <= 1'b0;
      phase_hi = hi;
      phase_lo = lo;
   endtask

   // Ends the series so nothing is held, then lets the block drain before
   // the settings may change.
   task automatic close_phase();
      send_flush();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly a trend that moves near the configured limits, with spikes,
   // odd time steps, absent samples and flushes mixed in.
   task automatic send_random_item(output bit counted);
      int                 kind;
      int                 step_kind;
      int                 rate_pick;
      int                 value_kind;
      longint             dt;
      longint             rate;
      longint             big;
      logic signed [31:0] value;
      kind = $urandom_range(0, 99);
      counted = 1'b1;
      if (kind < 5) begin
         counted = 1'b0;
         send_item($urandom, $urandom, 1'b0, 1'b0);
      end else if (kind < 8) begin
         send_flush();
      end else begin
         step_kind = $urandom_range(0, 99);
         if (step_kind < 60) dt = longint'($urandom_range(1, 4));
         else if (step_kind < 72) dt = 0;
         else if (step_kind < 78) dt = -longint'($urandom_range(1, 3));
         else if (step_kind < 88) dt = longint'($urandom_range(5, 1000));
         else dt = longint'($urandom_range(1, 2));
         if (step_kind < 94) gen_stamp = gen_stamp + 32'(dt);
         else gen_stamp = $urandom;

         rate_pick = $urandom_range(0, 6);
         case (rate_pick)
            0: rate = phase_hi;
            1: rate = phase_lo;
            2: rate = phase_hi + 1;
            3: rate = phase_lo - 1;
            4: rate = 0;
            default: begin
               if (phase_hi >= phase_lo)
                  rate = phase_lo + longint'($urandom) % (phase_hi - phase_lo + 1);
               else
                  rate = phase_hi;
            end
         endcase

         value_kind = $urandom_range(0, 99);
         if (value_kind < 8) begin
            gen_value = $urandom;
            value = gen_value;
         end else if (value_kind < 18) begin
            // The trend stays put so the next sample lands back on it.
            big = longint'($urandom_range(1000, 100000000));
            if ($urandom_range(0, 1)) big = -big;
            value = 32'(longint'(gen_value) + big);
         end else begin
            gen_value = 32'(longint'(gen_value) + rate * dt
                            + longint'($urandom_range(0, 2)) - 1);
            value = gen_value;
         end
         send_item(value, gen_stamp, 1'b1, 1'b0);
      end
   endtask

   task automatic send_directed();
      apply_settings(32'sd100, -32'sd100, MODE_EITHER, 1'b0);
      send_item(32'sd0, 32'd0, 1'b1, 1'b0);
      send_item(32'sd123, 32'd7, 1'b0, 1'b0);
      send_item(32'sd50, 32'd1, 1'b1, 1'b0);
      send_item(32'sd100000, 32'd2, 1'b1, 1'b0);
      send_item(32'sd150, 32'd3, 1'b1, 1'b0);
      // Zero time steps: rising, falling and flat.
      send_item(32'sd200, 32'd3, 1'b1, 1'b0);
      send_item(32'sd100, 32'd3, 1'b1, 1'b0);
      send_item(32'sd100, 32'd3, 1'b1, 1'b0);
      // Time running backward.
      send_item(32'sd0, 32'd1, 1'b1, 1'b0);
      send_item(32'sh8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_item(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_item(32'sh7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
      send_flush();
      send_flush();
      // A new series with rates sitting exactly on the limits.
      send_item(32'sd1000, 32'd10, 1'b1, 1'b0);
      send_item(32'sd1100, 32'd11, 1'b1, 1'b0);
      send_item(32'sd1000, 32'd12, 1'b1, 1'b0);
      send_item(32'sd1001, 32'd13, 1'b1, 1'b0);
      close_phase();
   endtask

   initial begin
      int idle_left;
      rsp_bus.ready = 1'b0;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (rx_free) begin
            rsp_bus.ready <= 1'b1;
         end else if (idle_left > 0) begin
            rsp_bus.ready <= 1'b0;
            idle_left--;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            idle_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 40);
         end
      end
   end

   initial begin
      int                 counted;
      bit                 took;
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      logic [1:0]         md;
      req_bus.valid         = 1'b0;
      req_bus.sample_value  = '0;
      req_bus.sample_time   = '0;
      req_bus.present       = 1'b0;
      req_bus.end_of_series = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_MAX_RATE;
      csr_data  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      send_directed();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin hi = 0;            lo = 0;             md = MODE_LEFT;   end
            1: begin hi = 32'sh7FFF_FFFF; lo = 32'sh8000_0000; md = MODE_RIGHT; end
            2: begin hi = 1000;         lo = -1000;         md = MODE_BOTH;   end
            3: begin hi = -5;           lo = 10;            md = MODE_EITHER; end
            4: begin hi = 300;          lo = 20;            md = MODE_LEFT;   end
            5: begin hi = $urandom_range(1, 5000); lo = -hi; md = MODE_RIGHT; end
            6: begin
               hi = $urandom_range(0, 200);
               lo = -$signed(32'($urandom_range(0, 200)));
               md = MODE_BOTH;
            end
            7: begin hi = $urandom;     lo = $urandom;      md = MODE_EITHER; end
            8: begin hi = 32'sh8000_0000; lo = 32'sh7FFF_FFFF; md = MODE_BOTH; end
            default: begin hi = 50;     lo = -50;           md = MODE_EITHER; end
         endcase
         apply_settings(hi, lo, md, p == 1);
         tx_steady = (p == 2) || (p == 5);
         rx_free   = (p == 5);
         // The receiver holds off while items keep coming, so the block backs up.
         if (p == 2) hold_request = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if (p == 3 && counted == PHASE_ITEMS / 2) begin
               req_bus.valid <= 1'b0;
               @(negedge clock);
               while (outstanding != 0) @(negedge clock);
            end
            send_random_item(took);
            if (took) counted++;
         end
         close_phase();
      end

      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * PERIOD);
      $display("Timeout with %0d results still expected", outstanding);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
